@@ rtl/hsa_pkg.sv @@
// Shared types and codes for the handle slot allocator.
package hsa_pkg;

    localparam int HANDLE_W    = 12;
    localparam int HANDLE_SPAN = 4096;
    localparam int STATUS_W    = 2;
    localparam int REQ_W       = 2;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 32;

    localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } hsa_state_t;

endpackage

@@ rtl/hsa_ram.sv @@
// Simple dual-port synchronous RAM with a registered read port.
module hsa_ram #(
    parameter  int WIDTH = 12,
    parameter  int DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/handle_slot_allocator.sv @@
// Handle slot allocator: LIFO free stack and live marks held in synchronous RAM.
//
// Channel | Dir | Beat contents (low bit first)
// s_      | in  | tdata: handle_in[11:0]; tuser: req_type[1:0]
// m_      | out | tdata: handle_out[11:0], status[13:12], live_count[25:14]
//
// A request is accepted in the idle state, which issues the RAM reads; the modify
// state then modifies the entries and writes them back once the output register
// can take the result. A result waits in an output register; the next request
// is accepted while it waits. Reset is synchronous and needs no clearing pass:
// live marks are read only below the head counter, where every entry is written.
module handle_slot_allocator
    import hsa_pkg::*;
#(
    parameter int CAPACITY = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // handle_in[11:0], zero fill
    input  logic [REQ_W-1:0]     s_tuser,   // req_type[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // handle_out, status, live_count, zero fill
);

    localparam int LIMIT = (CAPACITY < HANDLE_SPAN) ? CAPACITY : HANDLE_SPAN;
    localparam int AW    = $clog2(LIMIT);
    localparam logic [AW:0] LIMIT_V = (AW+1)'(LIMIT);

    hsa_state_t state_reg, state_next;

    logic [REQ_W-1:0]    req_reg;
    logic [HANDLE_W-1:0] h_reg;

    logic [AW-1:0] depth_reg, depth_next;
    logic [AW:0]   head_reg, head_next;
    logic [AW-1:0] total_reg, total_next;

    logic                m_valid_reg, m_valid_next;
    logic [HANDLE_W-1:0] hout_reg, hout_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;
    logic [HANDLE_W-1:0] count_reg;

    logic          accept;
    logic          commit;
    logic          live_rd;
    logic [AW-1:0] stack_rd;
    logic          live_we;
    logic [AW-1:0] live_waddr;
    logic          live_wdata;
    logic          stack_we;
    logic          in_range;
    logic          live_ok;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);

    hsa_ram #(.WIDTH(1), .DEPTH(LIMIT)) u_live (
        .aclk    (aclk),
        .wr_en   (live_we),
        .wr_addr (live_waddr),
        .wr_data (live_wdata),
        .rd_en   (accept),
        .rd_addr (s_tdata[AW-1:0]),
        .rd_data (live_rd)
    );

    hsa_ram #(.WIDTH(AW), .DEPTH(LIMIT)) u_stack (
        .aclk    (aclk),
        .wr_en   (stack_we),
        .wr_addr (depth_reg),
        .wr_data (h_reg[AW-1:0]),
        .rd_en   (accept),
        .rd_addr (depth_reg - 1'b1),
        .rd_data (stack_rd)
    );

    assign in_range = (h_reg != '0) && ({1'b0, h_reg} < (HANDLE_W+1)'(head_reg));
    assign live_ok  = in_range && live_rd;

    always_comb begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        head_next    = head_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg;
        hout_next    = hout_reg;
        stat_next    = stat_reg;
        live_we      = 1'b0;
        live_waddr   = h_reg[AW-1:0];
        live_wdata   = 1'b0;
        stack_we     = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    hout_next    = h_reg;
                    stat_next    = STAT_BAD;
                    case (req_reg)
                        REQ_ALLOC: begin
                            if (depth_reg != '0) begin
                                depth_next = depth_reg - 1'b1;
                                hout_next  = HANDLE_W'(stack_rd);
                                live_we    = 1'b1;
                                live_waddr = stack_rd;
                                live_wdata = 1'b1;
                                total_next = total_reg + 1'b1;
                                stat_next  = STAT_OK;
                            end else if (head_reg < LIMIT_V) begin
                                hout_next  = HANDLE_W'(head_reg);
                                live_we    = 1'b1;
                                live_waddr = head_reg[AW-1:0];
                                live_wdata = 1'b1;
                                head_next  = head_reg + 1'b1;
                                total_next = total_reg + 1'b1;
                                stat_next  = STAT_OK;
                            end else begin
                                hout_next = '0;
                                stat_next = STAT_FULL;
                            end
                        end
                        REQ_FREE: begin
                            if (live_ok) begin
                                live_we    = 1'b1;
                                live_wdata = 1'b0;
                                stack_we   = 1'b1;
                                depth_next = depth_reg + 1'b1;
                                total_next = total_reg - 1'b1;
                                stat_next  = STAT_OK;
                            end
                        end
                        REQ_LOOKUP: begin
                            stat_next = live_ok ? STAT_OK : STAT_BAD;
                        end
                        default: begin
                            stat_next = STAT_BAD;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            depth_reg   <= '0;
            head_reg    <= (AW+1)'(1);
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            head_reg    <= head_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_tuser;
            h_reg   <= s_tdata[HANDLE_W-1:0];
        end
        if (commit) begin
            hout_reg  <= hout_next;
            stat_reg  <= stat_next;
            count_reg <= HANDLE_W'(total_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2*HANDLE_W - STATUS_W){1'b0}},
                       count_reg, stat_reg, hout_reg};

    // Every nonzero handle below the head is either live or on the free stack.
    a_pool_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        ((HANDLE_W+1)'(depth_reg) + (HANDLE_W+1)'(total_reg) + (HANDLE_W+1)'(1))
            == (HANDLE_W+1)'(head_reg))
        else $error("free depth plus live count does not match head counter");

    // An accepted request is always followed by its modify cycle.
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted request did not enter the modify cycle");

    // A full status always carries the null handle.
    a_full_null: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (stat_reg == STAT_FULL)) |-> (hout_reg == '0))
        else $error("full status with a non-null handle");

    // A stalled result is not overwritten.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

@@ sim/handle_slot_allocator_tb.sv @@
// Self-checking testbench for the handle slot allocator with a scoreboard of expected results.
`timescale 1ns / 100ps

module handle_slot_allocator_tb;
    import hsa_pkg::*;

    localparam int CAPACITY    = 4096;
    localparam int POOL_LIMIT  = (CAPACITY < HANDLE_SPAN) ? CAPACITY : HANDLE_SPAN;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 20;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] live_count;
    } answer_t;

    class handle_pool_scoreboard;
        bit                  live_mark [HANDLE_SPAN];
        logic [HANDLE_W-1:0] free_stack [HANDLE_SPAN];
        int                  free_depth;
        int                  head_index;
        logic [HANDLE_W-1:0] live_total;
        answer_t             pending_answers [$];
        int                  mismatches;

        function new();
            foreach (live_mark[i]) live_mark[i] = 1'b0;
            free_depth = 0;
            head_index = 1;
            live_total = '0;
            mismatches = 0;
        endfunction

        function bit is_live(logic [HANDLE_W-1:0] h);
            return h != 0 && h < head_index && live_mark[h];
        endfunction

        function logic [HANDLE_W-1:0] pick_live();
            int h;
            if (head_index < 2) return '0;
            for (int i = 0; i < 32; i++) begin
                h = $urandom_range(head_index - 1, 1);
                if (live_mark[h]) return HANDLE_W'(h);
            end
            return HANDLE_W'(h);
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [HANDLE_W-1:0] h);
            answer_t ans;
            ans.handle_out = h;
            ans.status     = STAT_BAD;
            case (req)
                REQ_ALLOC: begin
                    if (free_depth > 0) begin
                        free_depth--;
                        ans.handle_out = free_stack[free_depth];
                        live_mark[ans.handle_out] = 1'b1;
                        live_total++;
                        ans.status = STAT_OK;
                    end else if (head_index < POOL_LIMIT) begin
                        ans.handle_out = head_index[HANDLE_W-1:0];
                        live_mark[ans.handle_out] = 1'b1;
                        head_index++;
                        live_total++;
                        ans.status = STAT_OK;
                    end else begin
                        ans.handle_out = '0;
                        ans.status     = STAT_FULL;
                    end
                end
                REQ_FREE: begin
                    if (is_live(h) && free_depth < HANDLE_SPAN) begin
                        live_mark[h] = 1'b0;
                        free_stack[free_depth] = h;
                        free_depth++;
                        live_total--;
                        ans.status = STAT_OK;
                    end
                end
                REQ_LOOKUP: begin
                    ans.status = is_live(h) ? STAT_OK : STAT_BAD;
                end
                default: ;
            endcase
            ans.live_count = live_total;
            pending_answers.push_back(ans);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("ERROR at %0t: %s", $realtime, msg);
        endfunction

        function void check_answer(logic [M_TDATA_W-1:0] beat);
            answer_t got;
            answer_t want;
            got.handle_out = beat[HANDLE_W-1:0];
            got.status     = beat[HANDLE_W +: STATUS_W];
            got.live_count = beat[HANDLE_W+STATUS_W +: HANDLE_W];
            if (pending_answers.size() == 0) begin
                flag($sformatf("result beat %h with nothing expected", beat));
                return;
            end
            want = pending_answers.pop_front();
            if (got.handle_out !== want.handle_out)
                flag($sformatf("handle_out expected %0d, got %0d",
                               want.handle_out, got.handle_out));
            if (got.status !== want.status)
                flag($sformatf("status expected %0d, got %0d", want.status, got.status));
            if (got.live_count !== want.live_count)
                flag($sformatf("live_count expected %0d, got %0d",
                               want.live_count, got.live_count));
        endfunction

        function void check_drained();
            if (pending_answers.size() != 0)
                flag($sformatf("%0d expected results never arrived", pending_answers.size()));
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // handle_in[11:0], zero fill
    logic [REQ_W-1:0]     s_tuser  = '0;   // req_type[1:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // handle_out, status, live_count, zero fill

    int src_idle  = 17;
    int sink_idle = 66;
    int stall_cycles = 0;
    handle_pool_scoreboard sb = new();

    handle_slot_allocator #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_answer(m_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_request(logic [REQ_W-1:0] req, logic [HANDLE_W-1:0] h);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(S_TDATA_W-HANDLE_W){1'b0}}, h};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(req, h);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending_answers.size() != 0);
    endtask

    task automatic run_random(int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_request(REQ_ALLOC, HANDLE_W'($urandom_range(4095)));
            else if (pick < 70)
                send_request(REQ_FREE, sb.pick_live());
            else if (pick < 85)
                send_request(REQ_LOOKUP, sb.pick_live());
            else if (pick < 93)
                send_request(REQ_LOOKUP, HANDLE_W'($urandom_range(4095)));
            else if (pick < 97)
                send_request(REQ_FREE, HANDLE_W'($urandom_range(4095)));
            else
                send_request(REQ_UNUSED, HANDLE_W'($urandom_range(4095)));
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(REQ_LOOKUP, 12'd0);
        send_request(REQ_LOOKUP, 12'd4095);
        send_request(REQ_FREE, 12'd0);
        send_request(REQ_FREE, 12'd4095);
        send_request(REQ_UNUSED, 12'd4095);
        send_request(REQ_ALLOC, 12'd0);
        send_request(REQ_ALLOC, 12'd0);
        send_request(REQ_ALLOC, 12'd0);
        send_request(REQ_LOOKUP, 12'd1);
        send_request(REQ_FREE, 12'd2);
        send_request(REQ_FREE, 12'd2);
        send_request(REQ_LOOKUP, 12'd2);
        send_request(REQ_FREE, 12'd3);
        send_request(REQ_ALLOC, 12'd0);
        send_request(REQ_ALLOC, 12'd0);
        send_request(REQ_ALLOC, 12'd0);
        send_request(REQ_FREE, 12'd5);
        send_request(REQ_ALLOC, 12'd4095);
        send_request(REQ_UNUSED, 12'd0);
        send_request(REQ_LOOKUP, 12'd4);

        run_random(200);
        wait_drained();

        src_idle  = 66;
        sink_idle = 17;
        run_random(200);

        src_idle  = 0;
        sink_idle = 0;
        send_request(REQ_ALLOC, 12'd4095);
        send_request(REQ_LOOKUP, 12'd4095);
        send_request(REQ_FREE, 12'd4095);
        send_request(REQ_FREE, sb.pick_live());
        send_request(REQ_ALLOC, 12'd0);
        send_request(REQ_ALLOC, 12'd0);
        send_request(REQ_ALLOC, 12'd0);
        run_random(40);

        s_tvalid <= 1'b0;
        while (sb.pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        sb.check_drained();
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/hsa_pkg.sv
rtl/hsa_ram.sv
rtl/handle_slot_allocator.sv
sim/handle_slot_allocator_tb.sv
